[sv/fpsa_pkg.sv]
// Shared types, constants and codes for the five-point stencil average block.
// No dependencies; every other file in sv/ but fpsa_frame_ram imports this package.
package fpsa_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int MAX_PLANES  = 4;
  localparam int SAMPLE_BITS = 8;

  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS * MAX_PLANES;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int SIZE_BITS   = $clog2(STORE_DEPTH + 1);
  localparam int PITCH_BITS  = $clog2(MAX_COLS * MAX_PLANES + 1);
  localparam int ROW_BITS    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_BITS    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PLANE_BITS  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;

  // register field widths are fixed by the register map
  localparam int DIM_BITS    = 7;
  localparam int PLN_BITS    = 3;
  localparam int STEP_BITS   = 6;
  localparam int COORD_BITS  = ((ROW_BITS > COL_BITS ? ROW_BITS : COL_BITS) > STEP_BITS ?
                                (ROW_BITS > COL_BITS ? ROW_BITS : COL_BITS) : STEP_BITS) + 2;

  localparam int REG_COUNT    = 6;
  localparam int REG_IDX_BITS = $clog2(REG_COUNT);
  localparam int PADDR_BITS   = REG_IDX_BITS + 2;

  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_ROWS  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_COLS  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_PLANE_COUNT = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_ROW_STEP    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_COL_STEP    = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_EDGE_MODE   = 3'd5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   frame_done;
  } out_item_t;

  // effective configuration: dimensions already bounded to 1..MAX
  typedef struct packed {
    logic [DIM_BITS-1:0]   rows;
    logic [DIM_BITS-1:0]   cols;
    logic [PLN_BITS-1:0]   planes;
    logic [STEP_BITS-1:0]  row_step;
    logic [STEP_BITS-1:0]  col_step;
    logic                  edge_zero;
    logic [PITCH_BITS-1:0] pitch;
    logic [SIZE_BITS-1:0]  size;
    logic                  settled;
  } cfg_t;

  typedef enum logic [1:0] {
    NBR_UP,
    NBR_RIGHT,
    NBR_DOWN,
    NBR_LEFT
  } nbr_dir_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RD,
    SEQ_ACC,
    SEQ_HOLD
  } seq_state_t;

endpackage

[sv/fpsa_regs.sv]
// APB register file for the stencil block: raw registers, bounded view,
// and the registered row pitch and frame size. Depends on fpsa_pkg.
module fpsa_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpsa_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output fpsa_pkg::cfg_t                  cfg
);
  import fpsa_pkg::*;

  logic [DIM_BITS-1:0]   rows_r, cols_r;
  logic [PLN_BITS-1:0]   planes_r;
  logic [STEP_BITS-1:0]  row_step_r, col_step_r;
  logic                  edge_r;
  logic [PITCH_BITS-1:0] pitch_r;
  logic [SIZE_BITS-1:0]  size_r;
  logic [1:0]            settle_r;

  logic [DIM_BITS-1:0]     rows_b, cols_b;
  logic [PLN_BITS-1:0]     planes_b;
  logic                    wr;
  logic [REG_IDX_BITS-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_BITS-1:2];

  always_comb begin
    if (rows_r == '0) begin
      rows_b = DIM_BITS'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      rows_b = DIM_BITS'(MAX_ROWS);
    end else begin
      rows_b = rows_r;
    end
    if (cols_r == '0) begin
      cols_b = DIM_BITS'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      cols_b = DIM_BITS'(MAX_COLS);
    end else begin
      cols_b = cols_r;
    end
    if (planes_r == '0) begin
      planes_b = PLN_BITS'(1);
    end else if (int'(planes_r) > MAX_PLANES) begin
      planes_b = PLN_BITS'(MAX_PLANES);
    end else begin
      planes_b = planes_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= DIM_BITS'(64);
      cols_r     <= DIM_BITS'(64);
      planes_r   <= PLN_BITS'(1);
      row_step_r <= STEP_BITS'(1);
      col_step_r <= STEP_BITS'(1);
      edge_r     <= 1'b0;
      settle_r   <= 2'b11;
    end else begin
      settle_r <= {settle_r[0], wr};
      if (wr) begin
        case (idx)
          REG_FRAME_ROWS:  rows_r     <= pwdata[DIM_BITS-1:0];
          REG_FRAME_COLS:  cols_r     <= pwdata[DIM_BITS-1:0];
          REG_PLANE_COUNT: planes_r   <= pwdata[PLN_BITS-1:0];
          REG_ROW_STEP:    row_step_r <= pwdata[STEP_BITS-1:0];
          REG_COL_STEP:    col_step_r <= pwdata[STEP_BITS-1:0];
          REG_EDGE_MODE:   edge_r     <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // derived products settle through pitch_r and then size_r after a write; inputs are held off meanwhile
  always_ff @(posedge clk) begin
    pitch_r <= PITCH_BITS'(cols_b * planes_b);
    size_r  <= SIZE_BITS'(rows_b * pitch_r);
  end

  always_comb begin
    case (idx)
      REG_FRAME_ROWS:  prdata = 32'(rows_r);
      REG_FRAME_COLS:  prdata = 32'(cols_r);
      REG_PLANE_COUNT: prdata = 32'(planes_r);
      REG_ROW_STEP:    prdata = 32'(row_step_r);
      REG_COL_STEP:    prdata = 32'(col_step_r);
      REG_EDGE_MODE:   prdata = 32'(edge_r);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cfg.rows      = rows_b;
    cfg.cols      = cols_b;
    cfg.planes    = planes_b;
    cfg.row_step  = row_step_r;
    cfg.col_step  = col_step_r;
    cfg.edge_zero = edge_r;
    cfg.pitch     = pitch_r;
    cfg.size      = size_r;
    cfg.settled   = (settle_r == 2'b00);
  end

endmodule

[sv/fpsa_frame_ram.sv]
// Single-port frame store with synchronous, registered read.
// Generic; no package dependency.
module fpsa_frame_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[sv/fpsa_nbr_addr.sv]
// Neighbor address generator: offset, edge test, clamp and store address
// for one of the four neighbors. Depends on fpsa_pkg.
module fpsa_nbr_addr (
  input  fpsa_pkg::cfg_t                  cfg,
  input  fpsa_pkg::nbr_dir_t              dir,
  input  logic [fpsa_pkg::PLANE_BITS-1:0] plane,
  input  logic [fpsa_pkg::ROW_BITS-1:0]   row,
  input  logic [fpsa_pkg::COL_BITS-1:0]   col,
  output logic [fpsa_pkg::ADDR_BITS-1:0]  addr,
  output logic                            skip
);
  import fpsa_pkg::*;

  logic signed [COORD_BITS-1:0] rr, cc, rows_s, cols_s;
  logic                         row_off, col_off;
  logic [ROW_BITS-1:0]          row_c;
  logic [COL_BITS-1:0]          col_c;
  logic [SIZE_BITS-1:0]         sum;

  assign rows_s = signed'(COORD_BITS'(cfg.rows));
  assign cols_s = signed'(COORD_BITS'(cfg.cols));

  always_comb begin
    rr = signed'(COORD_BITS'(row));
    cc = signed'(COORD_BITS'(col));
    case (dir)
      NBR_UP:    rr = rr - signed'(COORD_BITS'(cfg.row_step));
      NBR_DOWN:  rr = rr + signed'(COORD_BITS'(cfg.row_step));
      NBR_RIGHT: cc = cc + signed'(COORD_BITS'(cfg.col_step));
      NBR_LEFT:  cc = cc - signed'(COORD_BITS'(cfg.col_step));
      default: ;
    endcase
  end

  always_comb begin
    row_off = (rr < 0) || (rr >= rows_s);
    col_off = (cc < 0) || (cc >= cols_s);
    skip    = cfg.edge_zero && (row_off || col_off);

    if (rr < 0) begin
      row_c = '0;
    end else if (rr >= rows_s) begin
      row_c = ROW_BITS'(cfg.rows - DIM_BITS'(1));
    end else begin
      row_c = rr[ROW_BITS-1:0];
    end
    if (cc < 0) begin
      col_c = '0;
    end else if (cc >= cols_s) begin
      col_c = COL_BITS'(cfg.cols - DIM_BITS'(1));
    end else begin
      col_c = cc[COL_BITS-1:0];
    end
  end

  // (row*cols + col)*planes + plane, with cols*planes already registered
  assign sum  = SIZE_BITS'(row_c * cfg.pitch) + SIZE_BITS'(col_c * cfg.planes)
              + SIZE_BITS'(plane);
  assign addr = sum[ADDR_BITS-1:0];

endmodule

[sv/fpsa_seq.sv]
// Request sequencer: load writes, four-read neighbor fetch, accumulation,
// position counters and the output register. Depends on fpsa_pkg, fpsa_nbr_addr.
module fpsa_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fpsa_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fpsa_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fpsa_pkg::out_item_t              out_data,
  output logic                             ram_en,
  output logic                             ram_we,
  output logic [fpsa_pkg::ADDR_BITS-1:0]   ram_addr,
  output logic [fpsa_pkg::SAMPLE_BITS-1:0] ram_wdata,
  input  logic [fpsa_pkg::SAMPLE_BITS-1:0] ram_rdata
);
  import fpsa_pkg::*;

  seq_state_t            state_r, state_nxt;
  nbr_dir_t              k_r, k_nxt;
  logic [ADDR_BITS-1:0]  load_pos_r, load_pos_nxt;
  logic [PLANE_BITS-1:0] plane_r, plane_nxt;
  logic [ROW_BITS-1:0]   row_r, row_nxt;
  logic [COL_BITS-1:0]   col_r, col_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic                  take_r, take_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  accept, out_free, push;
  logic [ADDR_BITS-1:0]  lp_eff, nbr_addr;
  logic [SIZE_BITS-1:0]  lp_inc;
  logic                  nbr_skip, pos_bad;
  logic [SUM_BITS-1:0]   total;
  logic [PLANE_BITS-1:0] plane_adv;
  logic [ROW_BITS-1:0]   row_adv;
  logic [COL_BITS-1:0]   col_adv;
  logic                  done;

  fpsa_nbr_addr u_nbr (
    .cfg   (cfg),
    .dir   (k_r),
    .plane (plane_r),
    .row   (row_r),
    .col   (col_r),
    .addr  (nbr_addr),
    .skip  (nbr_skip)
  );

  assign in_ready  = (state_r == SEQ_IDLE) && cfg.settled;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lp_eff = (SIZE_BITS'(load_pos_r) >= cfg.size) ? '0 : load_pos_r;
  assign lp_inc = SIZE_BITS'(lp_eff) + SIZE_BITS'(1);

  assign pos_bad = (PLN_BITS'(plane_r) >= cfg.planes) || (DIM_BITS'(row_r) >= cfg.rows)
                || (DIM_BITS'(col_r) >= cfg.cols);

  assign total = sum_r + (take_r ? SUM_BITS'(ram_rdata) : '0);

  // raster advance: column inner, then row, then plane
  always_comb begin
    plane_adv = plane_r;
    row_adv   = row_r;
    col_adv   = col_r + COL_BITS'(1);
    done      = 1'b0;
    if (DIM_BITS'(col_r) + DIM_BITS'(1) >= cfg.cols) begin
      col_adv = '0;
      row_adv = row_r + ROW_BITS'(1);
      if (DIM_BITS'(row_r) + DIM_BITS'(1) >= cfg.rows) begin
        row_adv   = '0;
        plane_adv = plane_r + PLANE_BITS'(1);
        if (PLN_BITS'(plane_r) + PLN_BITS'(1) >= cfg.planes) begin
          plane_adv = '0;
          done      = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: if (accept && in_data.command == CMD_EMIT) state_nxt = SEQ_RD;
      SEQ_RD:   if (k_r == NBR_LEFT) state_nxt = SEQ_ACC;
      SEQ_ACC:  state_nxt = out_free ? SEQ_IDLE : SEQ_HOLD;
      SEQ_HOLD: if (out_free) state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = nbr_addr;
    ram_wdata = in_data.sample;
    push      = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        if (accept && in_data.command == CMD_LOAD) begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = lp_eff;
        end
      end
      SEQ_RD:   ram_en = !nbr_skip;
      SEQ_ACC:  push = out_free;
      SEQ_HOLD: push = out_free;
      default: ;
    endcase
  end

  always_comb begin
    k_nxt         = k_r;
    load_pos_nxt  = load_pos_r;
    plane_nxt     = plane_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sum_nxt       = sum_r;
    take_nxt      = take_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    case (state_r)
      SEQ_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_LOAD) begin
            load_pos_nxt = (lp_inc >= cfg.size) ? '0 : lp_inc[ADDR_BITS-1:0];
          end else begin
            if (pos_bad) begin
              plane_nxt = '0;
              row_nxt   = '0;
              col_nxt   = '0;
            end
            sum_nxt  = '0;
            take_nxt = 1'b0;
            k_nxt    = NBR_UP;
          end
        end
      end
      SEQ_RD: begin
        sum_nxt  = total;
        take_nxt = !nbr_skip;
        k_nxt    = nbr_dir_t'(k_r + 2'd1);
      end
      SEQ_ACC, SEQ_HOLD: begin
        // HOLD keeps take clear, so total is the stored sum
        sum_nxt  = total;
        take_nxt = 1'b0;
        if (push) begin
          out_data_nxt.average    = total[SUM_BITS-1:2];
          out_data_nxt.frame_done = done;
          plane_nxt = plane_adv;
          row_nxt   = row_adv;
          col_nxt   = col_adv;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      load_pos_r  <= '0;
      plane_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      take_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_pos_r  <= load_pos_nxt;
      plane_r     <= plane_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      take_r      <= take_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[sv/five_point_stencil_average.sv]
// Five-point stencil average: a frame store loaded by requests, read back as
// the truncated mean of four neighbors of each position.
// Input channel in_*: command LOAD writes in_data.sample at the next raster
//   address (planes interleaved per cell); command EMIT asks for the next result.
// Output channel out_*: one result per EMIT, order plane, row, column;
//   frame_done marks the last result of the frame.
// Configuration: APB registers frame_rows, frame_cols, plane_count, row_step,
//   col_step, edge_mode at byte addresses 0, 4, ... 20; pready is always high.
// Timing: a LOAD is written in the cycle it is accepted. An EMIT keeps the input
//   closed until its result is loaded: the single-port frame memory serves the four
//   neighbor reads one per cycle, then the ACC step adds the last read and loads
//   the registered output.
// in_ready also drops after each register write and after reset, while the row
//   pitch and frame size products settle.
// Reset clears the load and emit positions and restores register defaults;
//   the frame store is not cleared and must be loaded before results are asked.
// A stalled receiver holds the result in the output register; LOAD requests are
//   still taken meanwhile, and a waiting EMIT stays in its final step.
// Depends on fpsa_pkg, fpsa_regs, fpsa_frame_ram, fpsa_seq.
module five_point_stencil_average (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fpsa_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fpsa_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpsa_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import fpsa_pkg::*;

  cfg_t                   cfg;
  logic                   ram_en, ram_we;
  logic [ADDR_BITS-1:0]   ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

  fpsa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpsa_frame_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  fpsa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // memory writes come only from accepted load requests
  a_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (in_valid && in_ready && in_data.command == CMD_LOAD))
    else $error("frame store written without a load request");

  // an emit keeps the input closed while its four reads run
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_EMIT)
    |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input accepted during neighbor fetch");

  // no request is taken while derived config products are settling
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite) |=> !in_ready ##1 !in_ready)
    else $error("input accepted right after a register write");
`endif

endmodule

[verif/stencil_checker.sv]
`timescale 1ns / 1ps
// Checker for the five-point stencil average: follows APB writes and accepted
// requests, predicts each averaged result and compares it with the result channel.
// Depends on fpsa_pkg for the payload types, register indexes and command codes.
module stencil_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  fpsa_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  fpsa_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [fpsa_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output int                              mismatches,
  output int                              awaiting,
  output int                              results_seen,
  output int                              loads_seen
);
  import fpsa_pkg::*;

  logic [SAMPLE_BITS-1:0] frame_mem [STORE_DEPTH];
  out_item_t              pending_results[$];

  logic [DIM_BITS-1:0]  rows_reg;
  logic [DIM_BITS-1:0]  cols_reg;
  logic [PLN_BITS-1:0]  planes_reg;
  logic [STEP_BITS-1:0] rstep_reg;
  logic [STEP_BITS-1:0] cstep_reg;
  logic                 zero_mode;

  int load_ptr;
  int e_plane;
  int e_row;
  int e_col;

  initial begin
    mismatches   = 0;
    awaiting     = 0;
    results_seen = 0;
    loads_seen   = 0;
  end

  // register values of 0 act as 1, values over the limit act as the limit
  function automatic int lim(int v, int top_v);
    if (v == 0) return 1;
    return (v > top_v) ? top_v : v;
  endfunction

  function automatic int tap(int r, int c, int plane, int rows, int cols, int planes);
    int ra;
    int ca;
    ra = r;
    ca = c;
    if (r < 0 || r >= rows || c < 0 || c >= cols) begin
      if (zero_mode) return 0;
      if (ra < 0) ra = 0;
      if (ra >= rows) ra = rows - 1;
      if (ca < 0) ca = 0;
      if (ca >= cols) ca = cols - 1;
    end
    return int'(frame_mem[ADDR_BITS'((ra * cols + ca) * planes + plane)]);
  endfunction

  function automatic void store_sample(logic [SAMPLE_BITS-1:0] smp);
    int frame_len;
    frame_len = lim(int'(rows_reg), MAX_ROWS) * lim(int'(cols_reg), MAX_COLS) *
                lim(int'(planes_reg), MAX_PLANES);
    if (load_ptr >= frame_len) load_ptr = 0;
    frame_mem[ADDR_BITS'(load_ptr)] = smp;
    load_ptr++;
    if (load_ptr >= frame_len) load_ptr = 0;
  endfunction

  function automatic out_item_t next_mean();
    int        rows;
    int        cols;
    int        planes;
    int        sum;
    out_item_t res;
    rows   = lim(int'(rows_reg), MAX_ROWS);
    cols   = lim(int'(cols_reg), MAX_COLS);
    planes = lim(int'(planes_reg), MAX_PLANES);
    // counters left beyond a shrunken frame restart from the top
    if (e_plane >= planes || e_row >= rows || e_col >= cols) begin
      e_plane = 0;
      e_row   = 0;
      e_col   = 0;
    end
    sum = tap(e_row - int'(rstep_reg), e_col, e_plane, rows, cols, planes)
        + tap(e_row, e_col + int'(cstep_reg), e_plane, rows, cols, planes)
        + tap(e_row + int'(rstep_reg), e_col, e_plane, rows, cols, planes)
        + tap(e_row, e_col - int'(cstep_reg), e_plane, rows, cols, planes);
    res.average    = SAMPLE_BITS'(sum >> 2);
    res.frame_done = 1'b0;
    e_col++;
    if (e_col >= cols) begin
      e_col = 0;
      e_row++;
      if (e_row >= rows) begin
        e_row = 0;
        e_plane++;
        if (e_plane >= planes) begin
          e_plane        = 0;
          res.frame_done = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pending_results.delete();
      rows_reg   = DIM_BITS'(64);
      cols_reg   = DIM_BITS'(64);
      planes_reg = PLN_BITS'(1);
      rstep_reg  = STEP_BITS'(1);
      cstep_reg  = STEP_BITS'(1);
      zero_mode  = 1'b0;
      load_ptr   = 0;
      e_plane    = 0;
      e_row      = 0;
      e_col      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_BITS-1:2])
          REG_FRAME_ROWS:  rows_reg   = pwdata[DIM_BITS-1:0];
          REG_FRAME_COLS:  cols_reg   = pwdata[DIM_BITS-1:0];
          REG_PLANE_COUNT: planes_reg = pwdata[PLN_BITS-1:0];
          REG_ROW_STEP:    rstep_reg  = pwdata[STEP_BITS-1:0];
          REG_COL_STEP:    cstep_reg  = pwdata[STEP_BITS-1:0];
          REG_EDGE_MODE:   zero_mode  = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result average=%0d frame_done=%0b",
                   $time, out_data.average, out_data.frame_done);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.average !== want.average) begin
            $display("%0t: average mismatch, expected %0d, got %0d",
                     $time, want.average, out_data.average);
            mismatches++;
          end
          if (out_data.frame_done !== want.frame_done) begin
            $display("%0t: frame_done mismatch, expected %0b, got %0b",
                     $time, want.frame_done, out_data.frame_done);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.command == CMD_LOAD) begin
          store_sample(in_data.sample);
          loads_seen++;
        end else begin
          pending_results.push_back(next_mean());
        end
      end
    end
    awaiting = pending_results.size();
  end

endmodule

[verif/five_point_stencil_average_tb.sv]
`timescale 1ns / 1ps
// Top of the five-point stencil average testbench: clock, reset, APB setup,
// request stimulus and verdict. Depends on fpsa_pkg, the block and stencil_checker.
module five_point_stencil_average_tb;
  import fpsa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int mismatches;
  int awaiting;
  int results_seen;
  int loads_seen;
  int cycle_count  = 0;
  int items_sent   = 0;
  int settings_run = 0;
  bit steady       = 1'b0;

  five_point_stencil_average DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  stencil_checker u_stencil_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .results_seen (results_seen),
    .loads_seen   (loads_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("five_point_stencil_average test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 10);
  end

  function automatic int dim_eff(int v, int top_v);
    if (v == 0) return 1;
    return (v > top_v) ? top_v : v;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // called just after a falling edge
  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, int value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic push_request(logic cmd, logic [SAMPLE_BITS-1:0] smp);
    while (!steady && $urandom_range(99) < 10) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{command: cmd, sample: smp};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // hold requests until every result is back, then let the emit pipe empty
  task automatic drain();
    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_regs(int rows, int cols, int planes, int rstep, int cstep, int mode);
    drain();
    write_reg(REG_FRAME_ROWS, rows);
    write_reg(REG_FRAME_COLS, cols);
    write_reg(REG_PLANE_COUNT, planes);
    write_reg(REG_ROW_STEP, rstep);
    write_reg(REG_COL_STEP, cstep);
    write_reg(REG_EDGE_MODE, mode);
    settings_run++;
  endtask

  // full frame load first so every neighbor read hits a written entry;
  // a negative emit count picks one at random
  task automatic run_setting(int rows, int cols, int planes, int rstep, int cstep,
                             int mode, int emits);
    int frame_len;
    int n_emit;
    set_regs(rows, cols, planes, rstep, cstep, mode);
    frame_len = dim_eff(rows, MAX_ROWS) * dim_eff(cols, MAX_COLS) *
                dim_eff(planes, MAX_PLANES);
    n_emit = emits;
    if (n_emit < 0) begin
      n_emit = $urandom_range(1, frame_len + frame_len / 2 + 1);
      if (n_emit > 300) n_emit = 300;
    end
    repeat (frame_len) push_request(CMD_LOAD, pick_sample());
    repeat (n_emit) begin
      if ($urandom_range(99) < 15) push_request(CMD_LOAD, pick_sample());
      push_request(CMD_EMIT, SAMPLE_BITS'($urandom));
    end
  endtask

  function automatic int rand_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return 0;
    if (roll < 10) return $urandom_range(65, 127);
    if (roll < 14) return $urandom_range(9, 20);
    return $urandom_range(1, 8);
  endfunction

  function automatic int rand_step();
    return ($urandom_range(99) < 60) ? $urandom_range(0, 3) : $urandom_range(0, 63);
  endfunction

  initial begin
    logic [SAMPLE_BITS-1:0] seed_px [9];
    int rows;
    int cols;
    int planes;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    seed_px   = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'h0F, 8'hF0, 8'h81};
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: 3x3 frame with extreme samples, full pass to frame_done, one wrap
    set_regs(3, 3, 1, 1, 1, 0);
    foreach (seed_px[i]) push_request(CMD_LOAD, seed_px[i]);
    repeat (10) push_request(CMD_EMIT, SAMPLE_BITS'($urandom));

    // register extremes: out-of-range dims, zero and maximum steps, both edge modes
    run_setting(127, 1, 1, 63, 0, 0, -1);
    run_setting(1, 64, 4, 0, 63, 1, -1);
    run_setting(0, 0, 0, 5, 5, 0, 3);
    run_setting(0, 0, 0, 0, 0, 1, 3);
    run_setting(2, 2, 7, 1, 1, 1, -1);
    // long stretch with no idling on either side
    steady = 1'b1;
    run_setting(64, 1, 4, 2, 0, 1, 100);
    steady = 1'b0;
    run_setting(3, 3, 1, 1, 1, 0, 4);

    while (items_sent < ITEM_TARGET) begin
      do begin
        rows   = rand_dim();
        cols   = rand_dim();
        planes = $urandom_range(0, 7);
      end while (dim_eff(rows, MAX_ROWS) * dim_eff(cols, MAX_COLS) *
                 dim_eff(planes, MAX_PLANES) > 256);
      run_setting(rows, cols, planes, rand_step(), rand_step(), $urandom_range(1), -1);
    end

    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d requests: %0d loads, %0d results checked, %0d register settings.",
             items_sent, loads_seen, results_seen, settings_run);
    if (mismatches == 0 && awaiting == 0) begin
      $display("five_point_stencil_average test passed");
    end else begin
      $display("five_point_stencil_average test failed");
    end
    $finish;
  end

endmodule
